>>> rtl/spq_pkg.sv
// shared types and constants for the stable priority ring queue
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CLS_BITS     = 2;

    typedef logic [CLS_BITS-1:0]     t_cls;
    typedef logic [PAYLOAD_BITS-1:0] t_pay;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    // contents of one cell
    typedef struct packed {
        logic vld;
        t_cls cls;
        t_pay pay;
    } t_slot;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        t_cls cls;
        t_pay pay;
    } t_cell_ctl;

endpackage

>>> rtl/spq_cell.sv
// one queue cell: holds a record, shifts toward tail on insert, toward head on remove
`timescale 1ns / 1ps

module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_slot    i_left,
    input  logic              i_left_gt,
    input  spq_pkg::t_slot    i_right,
    output spq_pkg::t_slot    o_slot,
    output logic              o_gt
);
    import spq_pkg::*;

    logic r_vld;
    t_cls r_cls;
    t_pay r_pay;
    t_slot n_slot;

    // new record belongs here or nearer the head when this cell is empty or of a later class
    assign o_gt   = !r_vld || (r_cls > i_ctl.cls);
    assign o_slot = '{vld: r_vld, cls: r_cls, pay: r_pay};

    always_comb begin
        n_slot = o_slot;
        if (i_ctl.rem) begin
            n_slot = i_right;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_slot = i_left;
            end else if (o_gt) begin
                n_slot = '{vld: 1'b1, cls: i_ctl.cls, pay: i_ctl.pay};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_slot.vld;
        end
        r_cls <= n_slot.cls;
        r_pay <= n_slot.pay;
    end

endmodule

>>> rtl/stable_priority_ring_queue_top.sv
// top level of the stable priority queue built as a row of shifting cells
`timescale 1ns / 1ps
//
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+------------------------------------
// in      | input     | i_in_valid / o_in_stall  | i_mode, i_priority_req, i_payload
// out     | output    | o_out_valid / i_out_stall| o_status, o_out_priority, o_out_payload
//
// one transaction per clock: every cell compares its class with the new one in
// parallel, so an insert or a remove finishes in the cycle it is accepted
// the result sits in an output register and appears the cycle after acceptance
// the input stalls only while that register holds a result the sink is stalling
// synchronous active-low reset empties every cell; no clearing pass is needed
//
module stable_priority_ring_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [1:0]  i_priority_req,
    input  logic [31:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_out_priority,
    output logic [31:0] o_out_payload
);
    import spq_pkg::*;

    // cell 0 is the head; occupied cells are contiguous and sorted by class,
    // arrival order kept inside a class
    t_slot     w_slot  [QUEUE_DEPTH];
    logic      w_gt    [QUEUE_DEPTH];
    t_slot     w_left  [QUEUE_DEPTH];
    logic      w_lgt   [QUEUE_DEPTH];
    t_slot     w_right [QUEUE_DEPTH];
    t_cell_ctl w_ctl;

    logic w_accept;
    logic w_full;
    logic w_empty;

    logic    r_out_valid;
    t_status r_status;
    t_cls    r_out_cls;
    t_pay    r_out_pay;
    t_status n_status;
    t_cls    n_out_cls;
    t_pay    n_out_pay;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = w_slot[QUEUE_DEPTH-1].vld;
    assign w_empty    = !w_slot[0].vld;

    // command to the cells: only a transaction that changes the queue moves them
    always_comb begin
        w_ctl.ins = w_accept && (t_mode'(i_mode) == MODE_INSERT) && !w_full;
        w_ctl.rem = w_accept && (t_mode'(i_mode) == MODE_REMOVE) && !w_empty;
        w_ctl.cls = i_priority_req;
        w_ctl.pay = t_pay'(i_payload);
    end

    // neighbor wiring; the ends see an empty slot and no insert from outside
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0) begin
                w_left[i] = '0;
                w_lgt[i]  = 1'b0;
            end else begin
                w_left[i] = w_slot[i-1];
                w_lgt[i]  = w_gt[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin
                w_right[i] = '0;
            end else begin
                w_right[i] = w_slot[i+1];
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left[g]),
            .i_left_gt (w_lgt[g]),
            .i_right   (w_right[g]),
            .o_slot    (w_slot[g]),
            .o_gt      (w_gt[g])
        );
    end

    // result of the accepted transaction
    always_comb begin
        n_status  = ST_DONE;
        n_out_cls = '0;
        n_out_pay = '0;
        if (t_mode'(i_mode) == MODE_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end else begin
            n_out_cls = w_slot[0].cls;
            n_out_pay = w_slot[0].pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_status  <= n_status;
            r_out_cls <= n_out_cls;
            r_out_pay <= n_out_pay;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out_cls;
    assign o_out_payload  = 32'(r_out_pay);

endmodule
